[rtl/des_pkg.sv]
// Shared types, constants and name-trimming helpers for the directory entry search block.
// No dependencies; every other file in rtl/ imports this package.

package des_pkg;

  // Directory entry marker bytes and the character that ends an 8.3 name field.
  localparam logic [7:0] MARK_END      = 8'h00;
  localparam logic [7:0] MARK_DELETED  = 8'hE5;
  localparam logic [7:0] ATTR_LONGNAME = 8'h0F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  localparam int unsigned COUNT_W = 17;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEARCH_MODE  = 2'd0;
  localparam logic [1:0] REG_TARGET_INDEX = 2'd1;
  localparam logic [1:0] REG_SEARCH_BASE  = 2'd2;
  localparam logic [1:0] REG_SEARCH_EXT   = 2'd3;

  localparam logic MODE_INDEX = 1'b0;
  localparam logic MODE_NAME  = 1'b1;

  typedef enum logic [1:0] {
    ST_CONTINUE = 2'd0,
    ST_FOUND    = 2'd1,
    ST_END      = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  len;
  } base_trim_t;

  typedef struct packed {
    logic [23:0] bytes;
    logic [1:0]  len;
  } ext_trim_t;

  // Configuration as seen by the search logic, already trimmed and uppercased.
  typedef struct packed {
    logic        mode;
    logic [15:0] target_index;
    base_trim_t  base;
    ext_trim_t   ext;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_cluster;
    logic [31:0] found_size;
    logic [7:0]  found_attrs;
    base_trim_t  base;
    ext_trim_t   ext;
  } result_t;

  function automatic logic [7:0] fix_byte(input logic [7:0] b, input logic upper);
    logic [7:0] r;
    r = b;
    if (upper && (b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) begin
      r = b - CASE_OFFSET;
    end
    return r;
  endfunction

  // Keeps bytes up to the first NUL (and the first space when stop_space is set).
  function automatic base_trim_t trim_base(input logic [63:0] v, input logic stop_space,
                                           input logic upper);
    base_trim_t r;
    logic       stop;
    logic [7:0] b;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = v[8*i +: 8];
      if ((b == MARK_END) || (stop_space && (b == CH_SPACE))) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r.bytes[8*i +: 8] = fix_byte(b, upper);
        r.len = r.len + 4'd1;
      end
    end
    return r;
  endfunction

  function automatic ext_trim_t trim_ext(input logic [23:0] v, input logic stop_space,
                                         input logic upper);
    ext_trim_t  r;
    logic       stop;
    logic [7:0] b;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 3; i++) begin
      b = v[8*i +: 8];
      if ((b == MARK_END) || (stop_space && (b == CH_SPACE))) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r.bytes[8*i +: 8] = fix_byte(b, upper);
        r.len = r.len + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

[rtl/directory_entry_search_top.sv]
// Top level of the directory entry search block: stream ports, input and result registers.
// Depends on des_pkg, des_cfg and des_core.
//
//  Channel  Direction  Beat contents
//  in_*     slave      tdata: entry_name, entry_ext, entry_attrs, cluster_high,
//                             cluster_low, entry_size; tuser: start_search
//  out_*    master     tdata: found_cluster, found_size, found_attrs, name_base,
//                             base_length, name_ext, ext_length; tuser: status
//  cfg_*    write      cfg_index selects search_mode, target_index, search_base, search_ext
//
// Every entry beat produces exactly one result beat; it passes from the input register
// to the result register. One entry is accepted per cycle while the output side is ready;
// the rate is set by the single evaluation stage between the input and result registers.
// Reset is synchronous and active low; it empties both registers and clears the search state.
// When out_tready is low and the result register is full, an entry in the input register
// stays there and in_tready is low, so no beat is lost or repeated; while the input
// register is still empty, one more entry is taken.

module directory_entry_search_top
  import des_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // Input entries.
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_name[63:0], entry_ext[87:64], entry_attrs[95:88], cluster_high[111:96],
  // cluster_low[127:112], entry_size[159:128]
  input  logic [159:0] in_tdata,
  // start_search[0]
  input  logic         in_tuser,
  // Results.
  output logic         out_tvalid,
  input  logic         out_tready,
  // found_cluster[31:0], found_size[63:32], found_attrs[71:64], name_base[135:72],
  // base_length[139:136], name_ext[163:140], ext_length[165:164], zero fill[167:166]
  output logic [167:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  // Configuration writes.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  cfg_t cfg;

  // Input register: one entry waiting to be evaluated.
  logic         s1_valid_r, s1_valid_nxt;
  logic         s1_start_r;
  logic [159:0] s1_data_r;

  // Result register.
  logic         out_valid_r, out_valid_nxt;
  result_t      out_res_r;
  result_t      result;

  logic out_free;
  logic step;
  logic in_fire;

  // The result register can take a new value when it is empty or being drained now.
  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  des_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  des_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .start_search (s1_start_r),
    .entry        (s1_data_r),
    .cfg          (cfg),
    .result       (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser;
      s1_data_r  <= in_tdata;
    end
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {2'b00,
                       out_res_r.ext.len,
                       out_res_r.ext.bytes,
                       out_res_r.base.len,
                       out_res_r.base.bytes,
                       out_res_r.found_attrs,
                       out_res_r.found_size,
                       out_res_r.found_cluster};

  // Only a found beat carries entry fields.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_FOUND)) |-> (out_tdata == '0))
    else $error("non-found result carries nonzero fields");

  // A found name is never longer than the 8.3 field.
  a_base_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FOUND)) |-> (out_tdata[139:136] <= 4'd8))
    else $error("base length out of range");

  // Input backpressure only comes from a full, stalled pipeline.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without a full pipeline");

  // A stalled result is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

[rtl/des_cfg.sv]
// Configuration registers of the directory entry search block.
// Depends on des_pkg; the searched name is trimmed and uppercased as it is written.

module des_cfg
  import des_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_MODE:  cfg_nxt.mode         = cfg_wdata[0];
        REG_TARGET_INDEX: cfg_nxt.target_index = cfg_wdata[15:0];
        REG_SEARCH_BASE:  cfg_nxt.base         = trim_base(cfg_wdata, 1'b0, 1'b1);
        REG_SEARCH_EXT:   cfg_nxt.ext          = trim_ext(cfg_wdata[23:0], 1'b0, 1'b1);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/des_core.sv]
// Per-entry classification, name trimming, match decision and search state.
// Depends on des_pkg; the state advances once for each entry that leaves the input register.

module des_core
  import des_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         start_search,
  input  logic [159:0] entry,
  input  cfg_t         cfg,
  output result_t      result
);

  logic [COUNT_W-1:0] visible_count_r, visible_count_nxt;
  logic               finished_r, finished_nxt;

  logic [63:0] entry_name;
  logic [23:0] entry_ext;
  logic [7:0]  entry_attrs;
  logic [7:0]  first_byte;
  base_trim_t  nb;
  ext_trim_t   ne;
  logic [COUNT_W-1:0] count_eff;
  logic        finished_eff;
  logic        hit;

  assign entry_name  = entry[63:0];
  assign entry_ext   = entry[87:64];
  assign entry_attrs = entry[95:88];
  assign first_byte  = entry_name[7:0];

  assign nb = trim_base(entry_name, 1'b1, 1'b0);
  assign ne = trim_ext(entry_ext, 1'b1, 1'b0);

  // A start beat clears the search before the entry itself is judged.
  assign count_eff    = start_search ? '0 : visible_count_r;
  assign finished_eff = start_search ? 1'b0 : finished_r;

  always_comb begin
    if (cfg.mode == MODE_INDEX) begin
      hit = (count_eff == {1'b0, cfg.target_index});
    end else begin
      hit = (cfg.base == nb) && (cfg.ext == ne);
    end
  end

  always_comb begin
    result            = '0;
    result.status     = ST_CONTINUE;
    visible_count_nxt = count_eff;
    finished_nxt      = finished_eff;
    if (finished_eff) begin
      result.status = ST_IGNORED;
    end else if (first_byte == MARK_END) begin
      result.status = ST_END;
      finished_nxt  = 1'b1;
    end else if ((first_byte == MARK_DELETED) || (entry_attrs == ATTR_LONGNAME)) begin
      result.status = ST_CONTINUE;
    end else begin
      if (count_eff != '1) begin
        visible_count_nxt = count_eff + 1'b1;
      end
      if (hit) begin
        finished_nxt         = 1'b1;
        result.status        = ST_FOUND;
        result.found_cluster = {entry[111:96], entry[127:112]};
        result.found_size    = entry[159:128];
        result.found_attrs   = entry_attrs;
        result.base          = nb;
        result.ext           = ne;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visible_count_r <= '0;
      finished_r      <= 1'b0;
    end else if (step) begin
      visible_count_r <= visible_count_nxt;
      finished_r      <= finished_nxt;
    end
  end

endmodule
